// ===== rtl/rfci_pkg.sv =====
// rfci_pkg: shared types, widths and helpers for the finite cylinder intersect block
// used by rfci_front, rfci_queue, rfci_back and ray_finite_cylinder_intersect
package rfci_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int H_W             = 66;   // h = px*dx + pz*dz
    localparam int M_W             = 67;   // magnitude of a root numerator
    localparam int P_W             = 99;   // numerator times direction
    localparam int Q_W             = 41;   // quotient bits kept before the clamp
    localparam int NUM_LANES       = 6;    // two roots by three axes

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_z;
    } t_ray_out;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] radius;
        logic        [30:0] height;
    } t_cyl_cfg;

    // word handed from the front to the back
    typedef struct packed {
        logic                  miss;
        logic [63:0]           a;
        logic signed [H_W-1:0] h;
        logic [63:0]           s;
        t_ray_in               ray;
    } t_fwd;

    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        logic signed [31:0] res;
        if (v > 44'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -44'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/rfci_front.sv =====
// rfci_front: offsets, products, discriminant and a 64-stage integer square root
// depends on rfci_pkg; feeds rfci_queue
module rfci_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  rfci_pkg::t_ray_in i_ray,
    input  rfci_pkg::t_cyl_cfg i_cfg,
    output logic              o_valid,
    output rfci_pkg::t_fwd    o_word
);

    localparam int SQ_STEPS = 64;

    // stage 1: offsets from the axis
    logic                r_v1;
    rfci_pkg::t_ray_in   r_ray1;
    logic signed [32:0]  r_px1, r_pz1;
    logic [30:0]         r_rad1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ray1 <= i_ray;
        r_px1  <= 33'(i_ray.origin_x) - 33'(i_cfg.center_x);
        r_pz1  <= 33'(i_ray.origin_z) - 33'(i_cfg.center_z);
        r_rad1 <= i_cfg.radius;
    end

    // stage 2: products
    logic signed [63:0] w_dxx, w_dzz;
    logic signed [64:0] w_pxdz, w_pzdx, w_pxdx, w_pzdz;
    logic [61:0]        w_rr;

    assign w_dxx  = r_ray1.dir_x * r_ray1.dir_x;
    assign w_dzz  = r_ray1.dir_z * r_ray1.dir_z;
    assign w_pxdz = r_px1 * r_ray1.dir_z;
    assign w_pzdx = r_pz1 * r_ray1.dir_x;
    assign w_pxdx = r_px1 * r_ray1.dir_x;
    assign w_pzdz = r_pz1 * r_ray1.dir_z;
    assign w_rr   = r_rad1 * r_rad1;

    logic               r_v2;
    rfci_pkg::t_ray_in  r_ray2;
    logic [63:0]        r_dxx2, r_dzz2;
    logic signed [64:0] r_pxdz2, r_pzdx2, r_pxdx2, r_pzdz2;
    logic [61:0]        r_rr2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ray2  <= r_ray1;
        r_dxx2  <= w_dxx;
        r_dzz2  <= w_dzz;
        r_pxdz2 <= w_pxdz;
        r_pzdx2 <= w_pzdx;
        r_pxdx2 <= w_pxdx;
        r_pzdz2 <= w_pzdz;
        r_rr2   <= w_rr;
    end

    // stage 3: sums
    logic [63:0]                     w_a;
    logic signed [rfci_pkg::H_W-1:0] w_cross, w_cabs, w_h;

    assign w_a     = r_dxx2 + r_dzz2;
    assign w_cross = r_pxdz2 - r_pzdx2;
    assign w_cabs  = w_cross[rfci_pkg::H_W-1] ? -w_cross : w_cross;
    assign w_h     = r_pxdx2 + r_pzdz2;

    logic                            r_v3;
    rfci_pkg::t_ray_in               r_ray3;
    logic [63:0]                     r_a3, r_crlo3;
    logic signed [rfci_pkg::H_W-1:0] r_h3;
    logic [61:0]                     r_rr3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ray3  <= r_ray2;
        r_a3    <= w_a;
        r_crlo3 <= w_cabs[63:0];
        r_h3    <= w_h;
        r_rr3   <= r_rr2;
    end

    // stage 4: 32x32 partial products of a*r^2 and cross^2
    logic [63:0] w_ll, w_lh, w_hl, w_hh, w_cll, w_clh, w_chh;

    assign w_ll  = r_a3[31:0]  * r_rr3[31:0];
    assign w_lh  = r_a3[31:0]  * r_rr3[61:32];
    assign w_hl  = r_a3[63:32] * r_rr3[31:0];
    assign w_hh  = r_a3[63:32] * r_rr3[61:32];
    assign w_cll = r_crlo3[31:0]  * r_crlo3[31:0];
    assign w_clh = r_crlo3[31:0]  * r_crlo3[63:32];
    assign w_chh = r_crlo3[63:32] * r_crlo3[63:32];

    logic                            r_v4, r_miss4;
    rfci_pkg::t_ray_in               r_ray4;
    logic [63:0]                     r_a4;
    logic signed [rfci_pkg::H_W-1:0] r_h4;
    logic [63:0]                     r_ll4, r_lh4, r_hl4, r_hh4, r_cll4, r_clh4, r_chh4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ray4  <= r_ray3;
        r_a4    <= r_a3;
        r_h4    <= r_h3;
        r_miss4 <= (r_a3 == 64'd0);
        r_ll4   <= w_ll;
        r_lh4   <= w_lh;
        r_hl4   <= w_hl;
        r_hh4   <= w_hh;
        r_cll4  <= w_cll;
        r_clh4  <= w_clh;
        r_chh4  <= w_chh;
    end

    // stage 5: assemble the wide products
    logic [127:0] w_ar2, w_cr2;

    assign w_ar2 = {r_hh4, 64'd0} + {32'd0, r_lh4, 32'd0} + {32'd0, r_hl4, 32'd0}
                 + {64'd0, r_ll4};
    assign w_cr2 = {r_chh4, 64'd0} + {31'd0, r_clh4, 33'd0} + {64'd0, r_cll4};

    logic                            r_v5, r_miss5;
    rfci_pkg::t_ray_in               r_ray5;
    logic [63:0]                     r_a5;
    logic signed [rfci_pkg::H_W-1:0] r_h5;
    logic [127:0]                    r_ar2_5, r_cr2_5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ray5  <= r_ray4;
        r_a5    <= r_a4;
        r_h5    <= r_h4;
        r_miss5 <= r_miss4;
        r_ar2_5 <= w_ar2;
        r_cr2_5 <= w_cr2;
    end

    // square root pipeline, two radicand bits a stage
    logic           r_sq_v    [0:SQ_STEPS];
    logic [65:0]    r_sq_rem  [0:SQ_STEPS];
    logic [63:0]    r_sq_root [0:SQ_STEPS];
    logic [127:0]   r_sq_val  [0:SQ_STEPS];
    rfci_pkg::t_fwd r_sq_ctx  [0:SQ_STEPS];
    rfci_pkg::t_fwd n_ctx0;

    always_comb begin
        n_ctx0      = '0;
        n_ctx0.miss = r_miss5 | (r_ar2_5 < r_cr2_5);
        n_ctx0.a    = r_a5;
        n_ctx0.h    = r_h5;
        n_ctx0.ray  = r_ray5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_val[0]  <= r_ar2_5 - r_cr2_5;
        r_sq_ctx[0]  <= n_ctx0;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [67:0] w_rem2, w_trial, w_diff;
        logic        w_ge;

        assign w_rem2  = {r_sq_rem[k], r_sq_val[k][127:126]};
        assign w_trial = {2'b00, r_sq_root[k], 2'b01};
        assign w_ge    = (w_rem2 >= w_trial);
        assign w_diff  = w_rem2 - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_rem[k+1]  <= w_ge ? w_diff[65:0] : w_rem2[65:0];
            r_sq_root[k+1] <= {r_sq_root[k][62:0], w_ge};
            r_sq_val[k+1]  <= {r_sq_val[k][125:0], 2'b00};
            r_sq_ctx[k+1]  <= r_sq_ctx[k];
        end
    end

    assign o_valid = r_sq_v[SQ_STEPS];

    always_comb begin
        o_word   = r_sq_ctx[SQ_STEPS];
        o_word.s = r_sq_root[SQ_STEPS];
    end

endmodule

// ===== rtl/rfci_queue.sv =====
// rfci_queue: small word queue between the front and the back
// depends on rfci_pkg
module rfci_queue #(
    parameter int DEPTH = rfci_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rfci_pkg::t_fwd i_word,
    input  logic           i_pop,
    output logic           o_valid,
    output rfci_pkg::t_fwd o_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rfci_pkg::t_fwd   r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_pop;

    assign w_pop   = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/rfci_back.sv =====
// rfci_back: root numerators, six pipelined dividers, band test and result register
// depends on rfci_pkg; takes words from rfci_queue
module rfci_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rfci_pkg::t_fwd     i_word,
    input  rfci_pkg::t_cyl_cfg i_cfg,
    output logic               o_take,
    output logic               o_strobe,
    output rfci_pkg::t_ray_out o_result
);

    localparam int L  = rfci_pkg::NUM_LANES;
    localparam int QW = rfci_pkg::Q_W;

    typedef struct packed {
        logic              miss;
        logic [63:0]       a;
        rfci_pkg::t_ray_in ray;
        logic [L-1:0]      qneg;
        logic [L-1:0]      clamp;
    } t_bctx;

    // back is always ready
    assign o_take = i_valid;

    // stage 1: numerators -h - s and -h + s
    logic signed [67:0] w_hx, w_sx, w_num [0:1];

    assign w_hx     = i_word.h;
    assign w_sx     = {4'd0, i_word.s};
    assign w_num[0] = -w_hx - w_sx;
    assign w_num[1] = -w_hx + w_sx;

    logic                        r_v1;
    rfci_pkg::t_fwd              r_w1;
    logic [rfci_pkg::M_W-1:0]    r_mag1 [0:1];
    logic                        r_nneg1 [0:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1 <= i_word;
        for (int r = 0; r < 2; r++) begin
            r_nneg1[r] <= w_num[r][67];
            r_mag1[r]  <= w_num[r][67] ? 67'(-w_num[r]) : w_num[r][66:0];
        end
    end

    // stage 2 partials, stage 3 sums, stage 4 clamp check
    logic                r_v2, r_v3;
    rfci_pkg::t_fwd      r_w2, r_w3;
    logic [104:0]        r_lim3;
    logic [63:0]         r_pl2 [0:L-1];
    logic [63:0]         r_pm2 [0:L-1];
    logic [34:0]         r_ph2 [0:L-1];
    logic [L-1:0]        r_qneg2, r_qneg3;
    logic [rfci_pkg::P_W-1:0] r_p3 [0:L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w2    <= r_w1;
        r_w3    <= r_w2;
        r_qneg3 <= r_qneg2;
        r_lim3  <= {1'b0, r_w2.a, 40'd0} + {41'd0, r_w2.a};
    end

    // divider state, one column per lane
    logic           r_dv_v   [0:QW];
    t_bctx          r_dv_ctx [0:QW];
    logic [63:0]    r_dv_rem [0:L-1][0:QW];
    logic [QW-1:0]  r_dv_w   [0:L-1][0:QW];
    logic [L-1:0]   w_clamp;
    t_bctx          n_ctx0;

    for (genvar l = 0; l < L; l++) begin : g_lane
        localparam int R = l / 3;
        localparam int D = l % 3;

        logic signed [31:0] w_d;
        logic [31:0]        w_dm;
        logic [rfci_pkg::P_W-1:0] w_p;

        assign w_d  = (D == 0) ? r_w1.ray.dir_x : ((D == 1) ? r_w1.ray.dir_y : r_w1.ray.dir_z);
        assign w_dm = w_d[31] ? -w_d : w_d;
        assign w_p  = {35'd0, r_pl2[l]} + {3'd0, r_pm2[l], 32'd0} + {r_ph2[l], 64'd0};
        assign w_clamp[l] = ({6'd0, r_p3[l]} >= r_lim3);

        always_ff @(posedge i_clk) begin
            r_pl2[l]   <= r_mag1[R][31:0]  * w_dm;
            r_pm2[l]   <= r_mag1[R][63:32] * w_dm;
            r_ph2[l]   <= r_mag1[R][66:64] * w_dm;
            r_qneg2[l] <= r_nneg1[R] ^ w_d[31];
            r_p3[l]    <= w_p;
            r_dv_rem[l][0] <= {6'd0, r_p3[l][98:41]};
            r_dv_w[l][0]   <= r_p3[l][40:0];
        end

        for (genvar k = 0; k < QW; k++) begin : g_step
            logic [64:0] w_rem2, w_diff;
            logic        w_ge;

            assign w_rem2 = {r_dv_rem[l][k], r_dv_w[l][k][QW-1]};
            assign w_ge   = (w_rem2 >= {1'b0, r_dv_ctx[k].a});
            assign w_diff = w_rem2 - {1'b0, r_dv_ctx[k].a};

            always_ff @(posedge i_clk) begin
                r_dv_rem[l][k+1] <= w_ge ? w_diff[63:0] : w_rem2[63:0];
                r_dv_w[l][k+1]   <= {r_dv_w[l][k][QW-2:0], w_ge};
            end
        end
    end

    always_comb begin
        n_ctx0.miss  = r_w3.miss;
        n_ctx0.a     = r_w3.a;
        n_ctx0.ray   = r_w3.ray;
        n_ctx0.qneg  = r_qneg3;
        n_ctx0.clamp = w_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_ctx[0] <= n_ctx0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_ctx
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_ctx[k+1] <= r_dv_ctx[k];
        end
    end

    // e1: coordinates of both roots and the height band test
    t_bctx              w_fc;
    logic signed [42:0] w_c [0:L-1];
    logic signed [42:0] r_c [0:L-1];
    logic               r_in [0:1];
    logic               r_ve1, r_miss_e1;

    assign w_fc = r_dv_ctx[QW];

    for (genvar l = 0; l < L; l++) begin : g_coord
        localparam int D = l % 3;

        logic [QW-1:0]      w_qm;
        logic signed [41:0] w_qv;
        logic signed [31:0] w_o;

        assign w_qm = w_fc.clamp[l] ? (QW'(1) << (QW - 1)) : r_dv_w[l][QW];
        assign w_qv = w_fc.qneg[l] ? -$signed({1'b0, w_qm}) : $signed({1'b0, w_qm});
        assign w_o  = (D == 0) ? w_fc.ray.origin_x
                    : ((D == 1) ? w_fc.ray.origin_y : w_fc.ray.origin_z);
        assign w_c[l] = w_o + w_qv;

        always_ff @(posedge i_clk) begin
            r_c[l] <= w_c[l];
        end
    end

    for (genvar r = 0; r < 2; r++) begin : g_band
        logic signed [43:0] w_dy;
        logic signed [44:0] w_dev, w_hgt;

        assign w_dy  = w_c[r*3+1] - i_cfg.center_y;
        assign w_dev = $signed({w_dy, 1'b0});
        assign w_hgt = $signed({14'd0, i_cfg.height});

        always_ff @(posedge i_clk) begin
            r_in[r] <= (w_dev >= -w_hgt) && (w_dev <= w_hgt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve1 <= 1'b0;
        end else begin
            r_ve1 <= r_dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_miss_e1 <= w_fc.miss;
    end

    // e2: pick the root, saturate, form normals
    logic signed [43:0] w_xe, w_ye, w_ze, w_nxe, w_nze;
    logic signed [31:0] w_xs, w_zs;
    logic               w_sel1, w_hit;
    rfci_pkg::t_ray_out n_out;

    assign w_sel1 = !r_in[0];
    assign w_hit  = !r_miss_e1 && (r_in[0] || r_in[1]);
    assign w_xe   = w_sel1 ? r_c[3] : r_c[0];
    assign w_ye   = w_sel1 ? r_c[4] : r_c[1];
    assign w_ze   = w_sel1 ? r_c[5] : r_c[2];
    assign w_xs   = rfci_pkg::sat32(w_xe);
    assign w_zs   = rfci_pkg::sat32(w_ze);
    assign w_nxe  = w_xs - i_cfg.center_x;
    assign w_nze  = w_zs - i_cfg.center_z;

    always_comb begin
        n_out = '0;
        if (w_hit) begin
            n_out.hit      = 1'b1;
            n_out.point_x  = w_xs;
            n_out.point_y  = rfci_pkg::sat32(w_ye);
            n_out.point_z  = w_zs;
            n_out.normal_x = rfci_pkg::sat32(w_nxe);
            n_out.normal_z = rfci_pkg::sat32(w_nze);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_ve1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_out;
    end

endmodule

// ===== rtl/ray_finite_cylinder_intersect.sv =====
// ray against a Y-aligned finite cylinder: one ray accepted every cycle, busy stays low
// the path from the accepting edge to the result strobe runs through the
// 64-stage square root in the front and the 41-stage dividers in the back
// results cannot be held off; each word shows for one cycle on o_strobe
// synchronous active-low reset clears the pipeline valids and loads the register defaults
// depends on rfci_pkg, rfci_front, rfci_queue, rfci_back
module ray_finite_cylinder_intersect #(
    parameter int QUEUE_DEPTH = rfci_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rfci_pkg::t_ray_in  i_ray,
    output logic               o_strobe,
    output rfci_pkg::t_ray_out o_result,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_HEIGHT   = 3'd4;

    rfci_pkg::t_cyl_cfg r_cfg;
    logic               w_accept, w_fv, w_qv, w_take;
    rfci_pkg::t_fwd     w_fword, w_qword;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.center_z <= '0;
            r_cfg.radius   <= 31'd65536;
            r_cfg.height   <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X: r_cfg.center_x <= i_cfg_data;
                REG_CENTER_Y: r_cfg.center_y <= i_cfg_data;
                REG_CENTER_Z: r_cfg.center_z <= i_cfg_data;
                REG_RADIUS:   r_cfg.radius   <= i_cfg_data[30:0];
                REG_HEIGHT:   r_cfg.height   <= i_cfg_data[30:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    rfci_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_ray    (i_ray),
        .i_cfg    (r_cfg),
        .o_valid  (w_fv),
        .o_word   (w_fword)
    );

    rfci_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fv),
        .i_word  (w_fword),
        .i_pop   (w_take),
        .o_valid (w_qv),
        .o_word  (w_qword)
    );

    rfci_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qv),
        .i_word   (w_qword),
        .i_cfg    (r_cfg),
        .o_take   (w_take),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
